// ===== rtl/core/wbs_pkg.sv =====
package wbs_pkg;

  localparam int DefChannels    = 6;
  localparam int DefBlockLen    = 200;
  localparam int DefLongMinmax  = 30;
  localparam int DefShortMinmax = 5;
  localparam int DefLongMean    = 60;
  localparam int DefShortMean   = 3;

  localparam int SAMPLE_W = 24;
  localparam int RATIO_W  = 32;
  localparam int SUM_W    = 32;
  localparam int COUNT_W  = 8;
  localparam int DIV_QW   = 48;
  localparam int DIV_VW   = 32;

  localparam logic signed [SAMPLE_W-1:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S24_MIN = 24'sh800000;

  typedef struct packed {
    logic                     start;
    logic signed [DIV_QW-1:0] dividend;
    logic signed [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MDIV,
    S_WRITE,
    S_MMWALK,
    S_MEWALK,
    S_AVS,
    S_AVL,
    S_RATIO,
    S_OUT
  } state_t;

endpackage

// ===== rtl/core/windowed_block_statistics.sv =====
// Windowed block statistics. Tagged samples (channel in tdata bits 2:0, sample in 26:3,
// tlast closes the channel's block) update per-channel block minimum, maximum and sum, so
// a sample that does not close a block is taken every cycle while no sequence runs. A closing
// sample starts a sequence that stores the block extremes and mean in history memories,
// walks them through one read port per memory and runs four divisions on one shared
// bit-serial divider; three divisions when the short mean is zero. The walk covers the n
// minmax entries held (up to LONG_MINMAX) and the m mean entries held (up to LONG_MEAN).
// One result per closed block leaves through an output register, so the next sample may
// enter while the result waits.
module windowed_block_statistics #(
  parameter int CHANNELS     = wbs_pkg::DefChannels,
  parameter int BLOCK_LEN    = wbs_pkg::DefBlockLen,
  parameter int LONG_MINMAX  = wbs_pkg::DefLongMinmax,
  parameter int SHORT_MINMAX = wbs_pkg::DefShortMinmax,
  parameter int LONG_MEAN    = wbs_pkg::DefLongMean,
  parameter int SHORT_MEAN   = wbs_pkg::DefShortMean
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // channel[2:0], sample[26:3], zero pad
  input  logic         in_tlast,   // last_of_block
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_channel[2:0], max_latest[26:3], min_latest[50:27], max_short[74:51],
  // min_short[98:75], max_long[122:99], min_long[146:123], avg_short[170:147],
  // avg_long[194:171], mean_ratio[226:195], zero pad
  output logic [231:0] out_tdata
);
  import wbs_pkg::*;

  localparam int CHW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FILL_MAX = (LONG_MINMAX > LONG_MEAN) ? LONG_MINMAX : LONG_MEAN;
  localparam int FW       = $clog2(FILL_MAX + 1);
  localparam int MMPW     = $clog2(LONG_MINMAX);
  localparam int MEPW     = $clog2(LONG_MEAN);
  localparam int MM_DEPTH = CHANNELS * LONG_MINMAX;
  localparam int ME_DEPTH = CHANNELS * LONG_MEAN;
  localparam int MMAW     = (MM_DEPTH > 1) ? $clog2(MM_DEPTH) : 1;
  localparam int MEAW     = (ME_DEPTH > 1) ? $clog2(ME_DEPTH) : 1;
  localparam int ACC_W    = SAMPLE_W + 8;

  // per-channel block state and history bookkeeping
  logic signed [SAMPLE_W-1:0] blk_min_r [CHANNELS];
  logic signed [SAMPLE_W-1:0] blk_max_r [CHANNELS];
  logic signed [SUM_W-1:0]    blk_sum_r [CHANNELS];
  logic [COUNT_W-1:0]         blk_cnt_r [CHANNELS];
  logic [FW-1:0]              fill_r    [CHANNELS];
  logic [MMPW-1:0]            mmwp_r    [CHANNELS];
  logic [MEPW-1:0]            mewp_r    [CHANNELS];

  logic [2*SAMPLE_W-1:0] mm_mem [MM_DEPTH];
  logic [SAMPLE_W-1:0]   me_mem [ME_DEPTH];
  logic [2*SAMPLE_W-1:0] mm_q_r;
  logic [SAMPLE_W-1:0]   me_q_r;

  state_t state_r, state_nxt;

  logic [2:0]              ch_in;
  logic [CHW-1:0]          chi;
  logic signed [SAMPLE_W-1:0] smp;
  logic                    ch_ok, accept, upd;
  logic signed [SAMPLE_W-1:0] nmin, nmax;
  logic signed [SUM_W-1:0] nsum;
  logic [COUNT_W-1:0]      ncnt;

  logic [2:0]              ch_r;
  logic [CHW-1:0]          chi_r;
  logic signed [SAMPLE_W-1:0] bmin_r, bmax_r, bmean_r;
  logic signed [SUM_W-1:0] bsum_r;
  logic [COUNT_W-1:0]      bcnt_r;

  logic [FW-1:0]   nmm_r, nme_r, nsmm_r, nsme_r, k_r;
  logic [MMPW-1:0] mmidx_r;
  logic [MEPW-1:0] meidx_r;
  logic            rd_v_r, rd_sh_r;
  logic signed [SAMPLE_W-1:0] mns_r, mxs_r, mnl_r, mxl_r, avs_r, avl_r;
  logic signed [ACC_W-1:0]    accs_r, accl_r;
  logic signed [RATIO_W-1:0]  ratio_r;
  logic                       started_r;

  logic [FW-1:0] fill_new;
  logic          issue, walk_done;
  logic          div_state;

  div_req_t                 div_req;
  logic                     div_done;
  logic signed [DIV_QW-1:0] div_quo;

  logic                out_tvalid_r;
  logic [231:0]        out_tdata_r;

  assign ch_in  = in_tdata[2:0];
  assign smp    = $signed(in_tdata[26:3]);
  assign chi    = CHW'(ch_in);
  assign ch_ok  = 32'(ch_in) < 32'(CHANNELS);
  assign in_tready = (state_r == S_IDLE);
  assign accept = in_tvalid && in_tready && ch_ok;

  assign upd  = blk_cnt_r[chi] < COUNT_W'(BLOCK_LEN);
  assign nmin = (upd && smp < blk_min_r[chi]) ? smp : blk_min_r[chi];
  assign nmax = (upd && smp > blk_max_r[chi]) ? smp : blk_max_r[chi];
  assign nsum = upd ? blk_sum_r[chi] + SUM_W'(smp) : blk_sum_r[chi];
  assign ncnt = upd ? blk_cnt_r[chi] + 1'b1 : blk_cnt_r[chi];

  assign fill_new = (fill_r[chi_r] < FW'(FILL_MAX)) ? fill_r[chi_r] + 1'b1 : fill_r[chi_r];

  assign issue     = ((state_r == S_MMWALK) && k_r < nmm_r) ||
                     ((state_r == S_MEWALK) && k_r < nme_r);
  assign walk_done = !issue && !rd_v_r;
  assign div_state = (state_r == S_MDIV) || (state_r == S_AVS) ||
                     (state_r == S_AVL) || (state_r == S_RATIO);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept && in_tlast) state_nxt = S_MDIV;
      S_MDIV:   if (div_done) state_nxt = S_WRITE;
      S_WRITE:  state_nxt = S_MMWALK;
      S_MMWALK: if (walk_done) state_nxt = S_MEWALK;
      S_MEWALK: if (walk_done) state_nxt = S_AVS;
      S_AVS:    if (div_done) state_nxt = S_AVL;
      S_AVL:    if (div_done) state_nxt = (avs_r == '0) ? S_OUT : S_RATIO;
      S_RATIO:  if (div_done) state_nxt = S_OUT;
      S_OUT:    if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    div_req.start    = div_state && !started_r;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_r)
      S_MDIV: begin
        div_req.dividend = DIV_QW'(bsum_r);
        div_req.divisor  = DIV_VW'(bcnt_r);
      end
      S_AVS: begin
        div_req.dividend = DIV_QW'(accs_r);
        div_req.divisor  = DIV_VW'(nsme_r);
      end
      S_AVL: begin
        div_req.dividend = DIV_QW'(accl_r);
        div_req.divisor  = DIV_VW'(nme_r);
      end
      S_RATIO: begin
        div_req.dividend = DIV_QW'(avl_r) <<< 16;
        div_req.divisor  = DIV_VW'(avs_r);
      end
      default: ;
    endcase
  end

  wbs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      started_r    <= 1'b0;
      rd_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        blk_min_r[i] <= S24_MAX;
        blk_max_r[i] <= S24_MIN;
        blk_sum_r[i] <= '0;
        blk_cnt_r[i] <= '0;
        fill_r[i]    <= '0;
        mmwp_r[i]    <= '0;
        mewp_r[i]    <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      if (div_req.start) started_r <= 1'b1;
      else if (div_done) started_r <= 1'b0;
      if (state_r == S_OUT && state_nxt == S_IDLE) out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      if (accept) begin
        if (in_tlast) begin
          blk_min_r[chi] <= S24_MAX;
          blk_max_r[chi] <= S24_MIN;
          blk_sum_r[chi] <= '0;
          blk_cnt_r[chi] <= '0;
        end else begin
          blk_min_r[chi] <= nmin;
          blk_max_r[chi] <= nmax;
          blk_sum_r[chi] <= nsum;
          blk_cnt_r[chi] <= ncnt;
        end
      end
      if (state_r == S_WRITE) begin
        fill_r[chi_r] <= fill_new;
        mmwp_r[chi_r] <= (32'(mmwp_r[chi_r]) == LONG_MINMAX - 1) ? '0 : mmwp_r[chi_r] + 1'b1;
        mewp_r[chi_r] <= (32'(mewp_r[chi_r]) == LONG_MEAN - 1) ? '0 : mewp_r[chi_r] + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept && in_tlast) begin
      ch_r   <= ch_in;
      chi_r  <= chi;
      bmin_r <= nmin;
      bmax_r <= nmax;
      bsum_r <= nsum;
      bcnt_r <= ncnt;
    end
    if (state_r == S_MDIV && div_done) bmean_r <= SAMPLE_W'(div_quo);
    if (state_r == S_AVS && div_done) avs_r <= SAMPLE_W'(div_quo);
    if (state_r == S_AVL && div_done) begin
      avl_r   <= SAMPLE_W'(div_quo);
      ratio_r <= '0;
    end
    if (state_r == S_RATIO && div_done) begin
      if (div_quo > DIV_QW'(32'sh7FFFFFFF))      ratio_r <= 32'sh7FFFFFFF;
      else if (div_quo < -(DIV_QW'(1) <<< 31))   ratio_r <= 32'sh80000000;
      else                                        ratio_r <= RATIO_W'(div_quo);
    end
    if (state_r == S_WRITE) begin
      nmm_r   <= (32'(fill_new) < LONG_MINMAX) ? fill_new : FW'(LONG_MINMAX);
      nme_r   <= (32'(fill_new) < LONG_MEAN) ? fill_new : FW'(LONG_MEAN);
      nsmm_r  <= (32'(fill_new) < SHORT_MINMAX) ? fill_new : FW'(SHORT_MINMAX);
      nsme_r  <= (32'(fill_new) < SHORT_MEAN) ? fill_new : FW'(SHORT_MEAN);
      k_r     <= '0;
      mmidx_r <= mmwp_r[chi_r];
      meidx_r <= mewp_r[chi_r];
      mns_r   <= S24_MAX;
      mnl_r   <= S24_MAX;
      mxs_r   <= S24_MIN;
      mxl_r   <= S24_MIN;
      accs_r  <= '0;
      accl_r  <= '0;
    end
    if (state_r == S_MMWALK && walk_done) k_r <= '0;
    if (issue) begin
      k_r     <= k_r + 1'b1;
      rd_sh_r <= (state_r == S_MMWALK) ? (k_r < nsmm_r) : (k_r < nsme_r);
      // walk from newest to oldest
      if (state_r == S_MMWALK)
        mmidx_r <= (mmidx_r == '0) ? MMPW'(LONG_MINMAX - 1) : mmidx_r - 1'b1;
      else
        meidx_r <= (meidx_r == '0) ? MEPW'(LONG_MEAN - 1) : meidx_r - 1'b1;
    end
    if (rd_v_r && state_r == S_MMWALK) begin
      if ($signed(mm_q_r[SAMPLE_W-1:0]) < mnl_r) mnl_r <= $signed(mm_q_r[SAMPLE_W-1:0]);
      if ($signed(mm_q_r[2*SAMPLE_W-1:SAMPLE_W]) > mxl_r)
        mxl_r <= $signed(mm_q_r[2*SAMPLE_W-1:SAMPLE_W]);
      if (rd_sh_r) begin
        if ($signed(mm_q_r[SAMPLE_W-1:0]) < mns_r) mns_r <= $signed(mm_q_r[SAMPLE_W-1:0]);
        if ($signed(mm_q_r[2*SAMPLE_W-1:SAMPLE_W]) > mxs_r)
          mxs_r <= $signed(mm_q_r[2*SAMPLE_W-1:SAMPLE_W]);
      end
    end
    if (rd_v_r && state_r == S_MEWALK) begin
      accl_r <= accl_r + ACC_W'($signed(me_q_r));
      if (rd_sh_r) accs_r <= accs_r + ACC_W'($signed(me_q_r));
    end
    if (state_r == S_OUT && state_nxt == S_IDLE) begin
      out_tdata_r <= {5'b0, ratio_r, avl_r, avs_r, mnl_r, mxl_r, mns_r, mxs_r,
                      bmin_r, bmax_r, ch_r};
    end
  end

  // history memories
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      mm_mem[MMAW'(32'(chi_r) * LONG_MINMAX + 32'(mmwp_r[chi_r]))] <= {bmax_r, bmin_r};
      me_mem[MEAW'(32'(chi_r) * LONG_MEAN + 32'(mewp_r[chi_r]))]   <= bmean_r;
    end
    mm_q_r <= mm_mem[MMAW'(32'(chi_r) * LONG_MINMAX + 32'(mmidx_r))];
    me_q_r <= me_mem[MEAW'(32'(chi_r) * LONG_MEAN + 32'(meidx_r))];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== rtl/core/wbs_div.sv =====
module wbs_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wbs_pkg::div_req_t                req,
  output logic                             done,
  output logic signed [wbs_pkg::DIV_QW-1:0] quo
);
  import wbs_pkg::*;

  localparam int CW = $clog2(DIV_QW + 1);

  logic                busy_r;
  logic                done_r;
  logic [CW-1:0]       cnt_r;
  logic [DIV_VW:0]     rem_r;
  logic [DIV_QW-1:0]   q_r;
  logic [DIV_VW-1:0]   dvs_r;
  logic                neg_r;
  logic signed [DIV_QW-1:0] quo_r;
  logic [DIV_VW:0]     rem_sh;
  logic                ge;

  assign rem_sh = {rem_r[DIV_VW-1:0], q_r[DIV_QW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_QW);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // magnitudes in, one quotient bit per cycle, sign restored at the end
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend[DIV_QW-1] ? -req.dividend : req.dividend;
      dvs_r <= req.divisor[DIV_VW-1] ? -req.divisor : req.divisor;
      rem_r <= '0;
      neg_r <= req.dividend[DIV_QW-1] ^ req.divisor[DIV_VW-1];
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        quo_r <= neg_r ? -$signed(q_r) : $signed(q_r);
      end else begin
        rem_r <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
        q_r   <= {q_r[DIV_QW-2:0], ge};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
